// ===== rtl/pgl_pkg.sv =====
// ----------------------------------------------------------------------------
// pgl_pkg
// Shared types, constants and helper functions of the glyph layout engine.
// ----------------------------------------------------------------------------
package pgl_pkg;

    localparam int NUM_GLYPHS     = 96;
    localparam int MAX_CELL_WIDTH = 64;
    localparam int GLYPH_W        = 7;
    localparam int WIDTH_W        = 16;
    localparam int CELL_W         = 7;
    localparam int ALPHA_W        = 8;
    localparam int CFG_DATA_W     = 8;

    localparam logic [15:0]        FIRST_PRINTABLE = 16'd32;
    localparam logic [15:0]        PAST_PRINTABLE  = 16'd127;
    localparam logic [GLYPH_W-1:0] FALLBACK_GLYPH  = 7'd95;
    localparam logic [GLYPH_W-1:0] LAST_GLYPH      = 7'(NUM_GLYPHS - 1);
    localparam logic [CELL_W-1:0]  CELL_LIMIT      = 7'(MAX_CELL_WIDTH);

    // configuration register indexes
    localparam logic CFG_CELL_WIDTH    = 1'b0;
    localparam logic CFG_INK_THRESHOLD = 1'b1;

    // item kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_CHAR  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [6:0]  glyph_index;
        logic [5:0]  column;
        logic [7:0]  alpha;
        logic [15:0] char_code;
        logic        first_char;
        logic [15:0] avail_width;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  glyph;
        logic [15:0] x_offset;
        logic [6:0]  advance;
        logic        visible;
        logic [15:0] total_width;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;       // take the input item, start the table read
        logic exec_pix;   // finish a pixel item (table update)
        logic exec_chr;   // finish a character item (layout, load result)
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_char;    // held item is a character
        logic out_busy;   // result register full and not taken this cycle
    } t_sts;

    // code unit -> glyph cell
    function automatic logic [GLYPH_W-1:0] map_glyph(input logic [15:0] code);
        logic [15:0] diff;
        begin
            diff = code - FIRST_PRINTABLE;
            if (code < FIRST_PRINTABLE || code >= PAST_PRINTABLE) begin
                map_glyph = FALLBACK_GLYPH;
            end else begin
                map_glyph = diff[GLYPH_W-1:0];
            end
        end
    endfunction

    // c / 3 for c <= 64 via reciprocal multiply (171 / 512)
    function automatic logic [CELL_W-1:0] div3(input logic [CELL_W-1:0] c);
        logic [15:0] prod;
        begin
            prod = 16'(c) * 16'd171;
            div3 = prod[15:9];
        end
    endfunction

endpackage

// ===== rtl/pgl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pgl_ctrl
// Item sequencer: accepts one item, waits for the table read, then finishes it.
// ----------------------------------------------------------------------------
module pgl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pgl_pkg::t_sts i_sts,
    output pgl_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_sts.is_char) begin
                    o_cmd.exec_pix = 1'b1;
                    n_state        = ST_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.exec_chr = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/pgl_datapath.sv =====
// ----------------------------------------------------------------------------
// pgl_datapath
// Config registers, ink width memory, string state and the result register.
// ----------------------------------------------------------------------------
module pgl_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_index,
    input  logic [pgl_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  pgl_pkg::t_in_item                      i_in_data,
    input  pgl_pkg::t_cmd                          i_cmd,
    output pgl_pkg::t_sts                          o_sts,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output pgl_pkg::t_out_item                     o_out_data
);

    // config
    logic [pgl_pkg::CELL_W-1:0]  r_cell_width;
    logic [pgl_pkg::ALPHA_W-1:0] r_ink_threshold;

    // held item
    pgl_pkg::t_in_item r_item;

    // ink width memory; per-entry valid bits give the all-zero reset
    logic [pgl_pkg::CELL_W-1:0]     r_ink_mem [pgl_pkg::NUM_GLYPHS];
    logic [pgl_pkg::NUM_GLYPHS-1:0] r_ink_vld;
    logic [pgl_pkg::CELL_W-1:0]     r_rd_data;
    logic                           r_rd_vld;
    logic [pgl_pkg::GLYPH_W-1:0]    r_addr;

    // string state
    logic [pgl_pkg::WIDTH_W-1:0] r_running;
    logic                        r_clipped;

    // result register
    logic               r_out_valid;
    pgl_pkg::t_out_item r_out;

    logic [pgl_pkg::GLYPH_W-1:0] rd_addr;
    logic [pgl_pkg::CELL_W-1:0]  eff_cell;
    logic [pgl_pkg::CELL_W-1:0]  stored;
    logic [pgl_pkg::CELL_W-1:0]  col1;
    logic                        pix_hit;
    logic [pgl_pkg::CELL_W-1:0]  adv;
    logic [pgl_pkg::WIDTH_W-1:0] x_before;
    logic                        clip_base;
    logic [pgl_pkg::WIDTH_W:0]   sum;
    logic [pgl_pkg::WIDTH_W-1:0] total;
    logic                        clip_next;

    // read address at accept; out-of-range pixel samples read entry 0 (unused)
    always_comb begin
        if (i_in_data.func == pgl_pkg::FUNC_CHAR) begin
            rd_addr = pgl_pkg::map_glyph(i_in_data.char_code);
        end else if (i_in_data.glyph_index <= pgl_pkg::LAST_GLYPH) begin
            rd_addr = i_in_data.glyph_index;
        end else begin
            rd_addr = '0;
        end
    end

    assign eff_cell = (r_cell_width > pgl_pkg::CELL_LIMIT) ? pgl_pkg::CELL_LIMIT : r_cell_width;
    assign stored   = r_rd_vld ? r_rd_data : '0;
    assign col1     = {1'b0, r_item.column} + 7'd1;

    assign pix_hit = (r_item.glyph_index <= pgl_pkg::LAST_GLYPH)
                  && (r_item.alpha > r_ink_threshold)
                  && (col1 <= eff_cell)
                  && (stored < col1);

    // character layout
    always_comb begin
        if (stored == '0) begin
            adv = pgl_pkg::div3(eff_cell);
        end else if (stored > eff_cell) begin
            adv = eff_cell;
        end else begin
            adv = stored;
        end
        x_before  = r_item.first_char ? '0 : r_running;
        clip_base = r_item.first_char ? 1'b0 : r_clipped;
        sum       = {1'b0, x_before} + {10'd0, adv};
        total     = sum[pgl_pkg::WIDTH_W] ? '1 : sum[pgl_pkg::WIDTH_W-1:0];
        clip_next = clip_base | (total > r_item.avail_width);
    end

    // memory array: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_pix && pix_hit) begin
            r_ink_mem[r_addr] <= col1;
        end
        if (i_cmd.load) begin
            r_rd_data <= r_ink_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
            r_addr <= rd_addr;
        end
        if (i_cmd.exec_chr) begin
            r_out.glyph       <= r_addr;
            r_out.x_offset    <= x_before;
            r_out.advance     <= adv;
            r_out.visible     <= ~clip_next;
            r_out.total_width <= total;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width    <= 7'd7;
            r_ink_threshold <= 8'd20;
            r_ink_vld       <= '0;
            r_rd_vld        <= 1'b0;
            r_running       <= '0;
            r_clipped       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pgl_pkg::CFG_CELL_WIDTH:    r_cell_width    <= i_cfg_data[pgl_pkg::CELL_W-1:0];
                    pgl_pkg::CFG_INK_THRESHOLD: r_ink_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_rd_vld <= r_ink_vld[rd_addr];
            end
            if (i_cmd.exec_pix && pix_hit) begin
                r_ink_vld[r_addr] <= 1'b1;
            end
            if (i_cmd.exec_chr) begin
                r_running   <= total;
                r_clipped   <= clip_next;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_char  = (r_item.func == pgl_pkg::FUNC_CHAR);
    assign o_sts.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ===== rtl/proportional_glyph_layout_core.sv =====
// ----------------------------------------------------------------------------
// proportional_glyph_layout_core
// Learns per-glyph ink widths from font pixel items and lays out strings.
// ----------------------------------------------------------------------------
// Sequence: an accepted item's table read is registered; in exec, a character's
//   result enters the output register when that can take it, or a pixel item
//   updates the table. No new item is taken until the last one is finished, as
//   the registered read of the ink width memory is followed by its update or the layout step.
// Reset (synchronous, i_rst_n low): config returns to cell_width 7 and
//   ink_threshold 20, all ink widths read as zero at once, string state clears.
// ----------------------------------------------------------------------------
module proportional_glyph_layout_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [pgl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pgl_pkg::t_in_item              i_in_data,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pgl_pkg::t_out_item             o_out_data
);

    pgl_pkg::t_cmd cmd;
    pgl_pkg::t_sts sts;

    // Sequencer: idle -> (accept, start table read) -> exec -> idle.
    // A character waits in exec only while the result register is full and stalled.
    pgl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: the ink width memory is read at accept and updated in exec,
    // so a following item always sees the write of the one before.
    pgl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/proportional_glyph_layout_chk.sv =====
// ----------------------------------------------------------------------------
// proportional_glyph_layout_chk
// Port-level checks of the layout engine, bound to the top level.
// ----------------------------------------------------------------------------
module proportional_glyph_layout_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input pgl_pkg::t_out_item             o_out_data
);

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // one item at a time: the cycle after an accept is always stalled
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while previous one in flight");

    // advance never exceeds the widest cell
    a_adv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.advance <= pgl_pkg::CELL_LIMIT))
        else $error("advance out of range");

    // running width never shrinks within one result
    a_total_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.total_width >= o_out_data.x_offset))
        else $error("total width below x offset");

endmodule

bind proportional_glyph_layout_core proportional_glyph_layout_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== verif/tb_proportional_glyph_layout_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_proportional_glyph_layout_core
// Self-checking bench for the glyph layout engine. Font pixel items and
// character items go through a valid/stall channel; a built-in predictor
// tracks ink widths and string state and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_proportional_glyph_layout_core;

    localparam int BLANK_DIVISOR = 3;
    localparam int WIDTH_MAX     = 65535;
    localparam int DRAIN_CYCLES  = 4;
    localparam int QUIET_LIMIT   = 500;   // cycles with no accepted item and no taken result

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic                           cfg_index = pgl_pkg::CFG_CELL_WIDTH;
    logic [pgl_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    pgl_pkg::t_in_item              in_item   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    pgl_pkg::t_out_item             out_item;

    // predictor state
    logic [6:0]         ink_width [pgl_pkg::NUM_GLYPHS];
    logic [15:0]        string_width;
    logic               string_clipped;
    logic [6:0]         cell_width_reg;
    logic [7:0]         ink_threshold_reg;
    pgl_pkg::t_out_item layout_q[$];

    int mismatches = 0;
    bit gaps_on    = 1'b1;

    proportional_glyph_layout_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void reset_layout_state();
        for (int g = 0; g < pgl_pkg::NUM_GLYPHS; g++) begin
            ink_width[g] = '0;
        end
        string_width      = '0;
        string_clipped    = 1'b0;
        cell_width_reg    = 7'd7;
        ink_threshold_reg = 8'd20;
    endfunction

    // cell widths above the maximum behave as the maximum
    function automatic int active_cell();
        return (int'(cell_width_reg) > pgl_pkg::MAX_CELL_WIDTH) ? pgl_pkg::MAX_CELL_WIDTH
                                                                 : int'(cell_width_reg);
    endfunction

    function automatic void predict_layout(input pgl_pkg::t_in_item item);
        int                 cell_w;
        int                 g;
        int                 adv;
        int                 total;
        pgl_pkg::t_out_item res;
        cell_w = active_cell();
        if (item.func == pgl_pkg::FUNC_PIXEL) begin
            // out-of-range glyphs and columns past the cell are dropped
            if (int'(item.glyph_index) < pgl_pkg::NUM_GLYPHS && item.alpha > ink_threshold_reg
                    && int'(item.column) + 1 <= cell_w) begin
                if (int'(ink_width[item.glyph_index]) < int'(item.column) + 1) begin
                    ink_width[item.glyph_index] = 7'(int'(item.column) + 1);
                end
            end
        end else begin
            if (item.first_char) begin
                string_width   = '0;
                string_clipped = 1'b0;
            end
            if (item.char_code < pgl_pkg::FIRST_PRINTABLE
                    || item.char_code >= pgl_pkg::PAST_PRINTABLE) begin
                g = int'(pgl_pkg::FALLBACK_GLYPH);
            end else begin
                g = int'(item.char_code) - int'(pgl_pkg::FIRST_PRINTABLE);
            end
            adv = int'(ink_width[g]);
            if (adv == 0) begin
                adv = cell_w / BLANK_DIVISOR;   // blank glyph
            end else if (adv > cell_w) begin
                adv = cell_w;                   // learned under a wider cell
            end
            total = int'(string_width) + adv;
            if (total > WIDTH_MAX) begin
                total = WIDTH_MAX;
            end
            res.glyph    = 7'(g);
            res.x_offset = string_width;
            res.advance  = 7'(adv);
            string_width = 16'(total);
            if (total > int'(item.avail_width)) begin
                string_clipped = 1'b1;          // sticky until the next string
            end
            res.visible     = ~string_clipped;
            res.total_width = 16'(total);
            layout_q.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking, stall generation and watchdog
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin : check_results
        pgl_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (layout_q.size() == 0) begin
                $error("result item with nothing expected: glyph %0d", out_item.glyph);
                mismatches++;
            end else begin
                want = layout_q.pop_front();
                compare_field("glyph", want.glyph, out_item.glyph);
                compare_field("x_offset", want.x_offset, out_item.x_offset);
                compare_field("advance", want.advance, out_item.advance);
                compare_field("visible", want.visible, out_item.visible);
                compare_field("total_width", want.total_width, out_item.total_width);
            end
        end
    end

    // receiver stalls in bursts of random length
    always @(posedge clk) begin : drive_out_stall
        int hold;
        if (hold > 0) begin
            out_stall <= 1'b1;
            hold--;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            hold = $urandom_range(0, 9);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : watchdog
        int quiet;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("proportional_glyph_layout_core: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // valid stays high after acceptance; a gap or a drain lowers it
    task automatic send_item(input pgl_pkg::t_in_item item);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        predict_layout(item);
    endtask

    function automatic pgl_pkg::t_in_item random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(pgl_pkg::t_in_item)-1:0];
    endfunction

    // unused fields carry random bits
    task automatic send_pixel(input int glyph, input int col, input int alpha);
        pgl_pkg::t_in_item item;
        item             = random_item();
        item.func        = pgl_pkg::FUNC_PIXEL;
        item.glyph_index = 7'(glyph);
        item.column      = 6'(col);
        item.alpha       = 8'(alpha);
        send_item(item);
    endtask

    task automatic send_char(input int code, input bit first, input int avail);
        pgl_pkg::t_in_item item;
        item             = random_item();
        item.func        = pgl_pkg::FUNC_CHAR;
        item.char_code   = 16'(code);
        item.first_char  = first;
        item.avail_width = 16'(avail);
        send_item(item);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (layout_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] cell_val, input logic [7:0] thr_val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= pgl_pkg::CFG_CELL_WIDTH;
        cfg_data  <= cell_val;
        @(posedge clk);
        cell_width_reg = cell_val[6:0];
        cfg_index <= pgl_pkg::CFG_INK_THRESHOLD;
        cfg_data  <= thr_val;
        @(posedge clk);
        ink_threshold_reg = thr_val;
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset defaults (cell 7, blank advance 2), code mapping edges, and a
    // string that starts without first_char
    task automatic test_code_mapping();
        send_char(0, 1'b0, 65535);
        send_char(31, 1'b0, 65535);
        send_char(32, 1'b1, 65535);
        send_char(126, 1'b0, 65535);
        send_char(127, 1'b0, 65535);
        send_char(16'hFFFF, 1'b0, 65535);
        send_char(16'h8041, 1'b0, 65535);
    endtask

    // threshold is strict, columns past the cell and glyphs past 95 are dropped
    task automatic test_ink_learning();
        send_pixel(33, 6, 21);
        send_pixel(34, 3, 20);
        send_pixel(35, 7, 255);
        send_pixel(96, 0, 255);
        send_pixel(127, 63, 255);
        send_pixel(95, 0, 255);
        send_pixel(0, 0, 0);
        send_char(65, 1'b1, 65535);
        send_char(66, 1'b0, 65535);
        send_char(67, 1'b0, 65535);
        send_char(200, 1'b0, 65535);
    endtask

    task automatic test_clipping();
        send_char(65, 1'b1, 0);        // zero width available
        send_char(66, 1'b0, 65535);    // stays clipped
        send_char(65, 1'b1, 9);
        send_char(65, 1'b0, 9);        // overflows the available width
        send_char(65, 1'b1, 65535);
    endtask

    // well-formed strings with interleaved font learning and some noise,
    // under several register settings including the extremes
    task automatic test_config_phases();
        logic [7:0] cells [6] = '{8'd64, 8'hFF, 8'd0, 8'd1, 8'd3, 8'd0};
        logic [7:0] thrs  [6] = '{8'd0, 8'd255, 8'd128, 8'd20, 8'd200, 8'd0};
        int         string_left;
        int         avail;
        int         cell_w;
        int         code;
        int         r;
        for (int p = 0; p < 6; p++) begin
            if (p == 5) begin
                set_config(8'($urandom), 8'($urandom));
            end else begin
                set_config(cells[p], thrs[p]);
            end
            cell_w      = active_cell();
            string_left = 0;
            for (int i = 0; i < 130; i++) begin
                if (i == 65) begin
                    wait_drained();    // sender holds off until all results are out
                end
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    send_item(random_item());
                end else if (r < 40) begin
                    send_pixel($urandom_range(0, pgl_pkg::NUM_GLYPHS - 1),
                               $urandom_range(0, (cell_w > 63) ? 63 : cell_w),
                               $urandom_range(0, 255));
                end else begin
                    if (string_left == 0 || $urandom_range(0, 9) == 0) begin
                        avail = $urandom_range(0, 12 * cell_w + 1);
                    end
                    code = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                                       : int'($urandom_range(32, 126));
                    send_char(code, string_left == 0, avail);
                    if (string_left == 0) begin
                        string_left = $urandom_range(1, 16);
                    end
                    string_left--;
                end
            end
        end
    endtask

    // one long string of full-width glyphs runs the width past 65535
    task automatic test_width_saturation();
        int code;
        set_config(8'd64, 8'd0);
        for (int g = 0; g < pgl_pkg::NUM_GLYPHS; g++) begin
            send_pixel(g, 63, 255);
        end
        for (int i = 0; i < 1060; i++) begin
            code = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                               : int'($urandom_range(32, 126));
            // near the end, a saturated width must still clip against 65534
            send_char(code, i == 0, (i >= 1020 && i[0]) ? 65534 : 65535);
        end
    endtask

    initial begin
        reset_layout_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_code_mapping();
        test_ink_learning();
        test_clipping();
        test_config_phases();
        gaps_on = 1'b0;      // final stretch runs at full rate
        test_width_saturation();
        wait_drained();
        if (mismatches == 0 && layout_q.size() == 0) begin
            $display("proportional_glyph_layout_core: match");
        end else begin
            $display("proportional_glyph_layout_core: mismatch");
        end
        $finish;
    end

endmodule
